// ===== src/busy_utilization_monitor_defines.svh =====
// Assertion helpers for the utilization monitor.
`ifndef BUSY_UTILIZATION_MONITOR_DEFINES_SVH
`define BUSY_UTILIZATION_MONITOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BUM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utilization monitor check failed");

// next-cycle implication, checked out of reset
`define BUM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utilization monitor check failed");

`endif

// ===== src/bum_pkg.sv =====
`default_nettype none
package bum_pkg;

  localparam logic [1:0] OP_RUN     = 2'd0;
  localparam logic [1:0] OP_STOP    = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_SUSPEND = 2'd3;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  localparam logic [31:0] NORM_LIMIT = 32'h00ff_ffff;
  localparam int unsigned WORD_BITS  = 32;

  typedef struct packed {
    logic [1:0]  operation;
    logic [62:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [31:0] utilization;
    logic        divide_fault;
  } out_word_t;

  // report job from front to back
  typedef struct packed {
    logic        zero_run;
    logic [31:0] work_n;
    logic [31:0] period_n;
  } job_t;

endpackage
`default_nettype wire

// ===== src/bum_front.sv =====
`default_nettype none
module bum_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire bum_pkg::in_word_t in_data,
  output logic                  q_push,
  output bum_pkg::job_t         q_job,
  input  wire logic             q_full
);
  import bum_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_PUSH} fstate_t;

  fstate_t     state_r;
  logic [15:0] tpr_r;
  logic [1:0]  mode_r;
  logic [16:0] tick_r;
  logic [62:0] work_r, acc_r, win_r;
  logic        ticking_r;
  logic [62:0] sh_work_r;
  logic [63:0] sh_span_r;
  job_t        job_r;

  logic        accept;
  logic [62:0] now, run_start, stop_end;
  logic [63:0] stop_sum, rep_sum, span;
  logic [62:0] stop_acc, rep_acc;
  logic [16:0] tick_inc;
  logic        below;
  logic [31:0] wn, pn;

  assign accept  = in_push && !in_full;
  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_job   = job_r;
  assign now     = in_data.timestamp;

  // run start clamp, stop and report accumulate, window span, tick compare
  always_comb begin
    run_start = (now < win_r) ? win_r : now;
    stop_end  = (now < work_r) ? work_r : now;
    stop_sum  = {1'b0, acc_r} + {1'b0, stop_end - work_r};
    stop_acc  = stop_sum[63] ? {63{1'b1}} : stop_sum[62:0];
    rep_sum   = {1'b0, acc_r} + {1'b0, now - work_r};
    rep_acc   = ((work_r != '0) && (now > work_r)) ?
                (rep_sum[63] ? {63{1'b1}} : rep_sum[62:0]) : acc_r;
    span      = {1'b0, now} - {1'b0, win_r};
    tick_inc  = tick_r + 17'd1;
    below     = $signed(tick_inc) < $signed({1'b0, tpr_r});
  end

  // normalize once the high word is gone
  always_comb begin
    wn = sh_work_r[31:0];
    pn = sh_span_r[31:0];
    if (pn > NORM_LIMIT) begin
      pn = pn >> 8;
    end else begin
      wn = wn << 8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      tpr_r     <= 16'd1;
      mode_r    <= MODE_INIT;
      tick_r    <= '1;
      work_r    <= '0;
      acc_r     <= '0;
      win_r     <= '0;
      ticking_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        tpr_r <= cfg_data;
      end
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            case (in_data.operation)
              OP_RUN: begin
                if (mode_r != MODE_RUN) begin
                  mode_r <= MODE_RUN;
                  work_r <= run_start;
                  if (!ticking_r) begin
                    ticking_r <= 1'b1;
                    tick_r    <= '0;
                    win_r     <= run_start;
                  end
                end
              end
              OP_STOP: begin
                if (mode_r != MODE_STOP) begin
                  mode_r <= MODE_STOP;
                  acc_r  <= stop_acc;
                  work_r <= '0;
                end
              end
              OP_SUSPEND: begin
                ticking_r <= 1'b0;
                mode_r    <= MODE_INIT;
                tick_r    <= '1;
                work_r    <= '0;
                acc_r     <= '0;
                win_r     <= '0;
              end
              default: begin
                if (ticking_r) begin
                  if (below) begin
                    tick_r <= tick_inc;
                    if (win_r == '0) win_r <= now;
                  end else begin
                    tick_r <= '0;
                    win_r  <= now;
                    if (acc_r == '0 && work_r == '0) begin
                      job_r   <= '{zero_run: 1'b1, work_n: '0, period_n: '0};
                      state_r <= F_PUSH;
                    end else begin
                      sh_work_r <= rep_acc;
                      sh_span_r <= span;
                      acc_r     <= '0;
                      if (work_r != '0) work_r <= now;
                      state_r   <= F_SHIFT;
                    end
                  end
                end
              end
            endcase
          end
        end
        F_SHIFT: begin
          // one bit per cycle until the window high word is clear
          if (sh_span_r[63:32] != '0) begin
            sh_span_r <= sh_span_r >> 1;
            sh_work_r <= sh_work_r >> 1;
          end else begin
            job_r   <= '{zero_run: 1'b0, work_n: wn, period_n: pn};
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/bum_queue.sv =====
`default_nettype none
module bum_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bum_pkg::job_t  push_job,
  output logic                full,
  input  wire logic           pop,
  output bum_pkg::job_t       pop_job,
  output logic                empty
);
  import bum_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (pop && !empty) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      cnt_r <= cnt_r + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// ===== src/bum_back.sv =====
`default_nettype none
module bum_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire bum_pkg::job_t  q_job,
  output logic                q_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output bum_pkg::out_word_t  out_data
);
  import bum_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_DONE} bstate_t;

  bstate_t     state_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, quo_r, dvs_r;
  logic        fault_r;
  logic        ovalid_r;
  out_word_t   odata_r;
  logic [32:0] trial;
  logic        slot_free;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_empty = !ovalid_r;
  assign out_data  = odata_r;
  assign slot_free = !ovalid_r || out_pop;
  assign trial     = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      // drop the output word once taken, unless a new one replaces it
      if (out_pop && ovalid_r && !((state_r == B_DONE) && slot_free)) ovalid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            dvs_r <= q_job.period_n;
            rem_r <= '0;
            cnt_r <= '0;
            if (q_job.zero_run || q_job.period_n == '0) begin
              quo_r   <= '0;
              fault_r <= !q_job.zero_run;
              state_r <= B_DONE;
            end else begin
              quo_r   <= q_job.work_n;
              fault_r <= 1'b0;
              state_r <= B_DIV;
            end
          end
        end
        B_DIV: begin
          // restoring division, one quotient bit per cycle
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= {rem_r[30:0], quo_r[31]};
            quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(WORD_BITS - 1)) state_r <= B_DONE;
        end
        B_DONE: begin
          if (slot_free) begin
            odata_r  <= '{utilization: quo_r, divide_fault: fault_r};
            ovalid_r <= 1'b1;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/busy_utilization_monitor.sv =====
// Latency: run, stop, suspend and a tick that ends no period finish at the accepting edge.
// Reporting tick: the front makes s = 0..32 normalize shifts (bit length of the window
// high word), then queues the job; no divide if the unit never ran or on a fault.
// Throughput: one input word per cycle while the front is idle; the input stalls for the
// shifts and queue push of each report; the serial divider takes one report at a time.
// Reset: synchronous active-low rst_n; period register returns to 1, queues empty.
`default_nettype none
`include "busy_utilization_monitor_defines.svh"
module busy_utilization_monitor #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire bum_pkg::in_word_t  in_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output bum_pkg::out_word_t      out_data
);
  import bum_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  bum_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .q_push(q_push), .q_job(push_job), .q_full(q_full)
  );

  bum_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(push_job), .full(q_full),
    .pop(q_pop), .pop_job(pop_job), .empty(q_empty)
  );

  bum_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_job(pop_job), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  `BUM_ASSERT_NOW(a_push_not_full, q_push, !q_full)
  `BUM_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)
  `BUM_ASSERT_NOW(a_fault_zero, !out_empty && out_data.divide_fault, out_data.utilization == '0)
  `BUM_ASSERT_NEXT(a_pop_consumes, q_pop && !q_push && q_full, !q_full)

endmodule
`default_nettype wire

// ===== sim/busy_utilization_monitor_test.sv =====
`timescale 1ns / 1ps
module busy_utilization_monitor_test;
  import bum_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam logic [62:0] TIME_MAX = 63'h7fff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  in_word_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_data;

  busy_utilization_monitor u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [15:0] period_cfg;
  logic [1:0]  mode;
  int          tick_cnt;
  logic [62:0] work_t0, busy_acc, win_t0;
  logic        ticking;
  logic [31:0] ratio;

  in_word_t  pending_words[$];
  out_word_t ratio_expect[$];
  int        errors = 0;
  bit        quiet = 0;      // idling switched off
  int unsigned stall_cycles = 0;

  function automatic logic [62:0] busy_saturate(logic [62:0] a, logic [62:0] d);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, d};
    return (s > {1'b0, TIME_MAX}) ? TIME_MAX : s[62:0];
  endfunction

  // model one accepted word; pushes the expected report if any
  task automatic predict_utilization(in_word_t w);
    logic [62:0] now;
    logic [63:0] span;
    logic [31:0] hi, wn, pn;
    int          shift;
    out_word_t   r;
    now = w.timestamp;
    case (w.operation)
      OP_RUN: begin
        if (mode != MODE_RUN) begin
          mode = MODE_RUN;
          if (now < win_t0) now = win_t0;
          work_t0 = now;
          if (!ticking) begin
            ticking = 1'b1;
            tick_cnt = 0;
            win_t0 = work_t0;
          end
        end
      end
      OP_STOP: begin
        if (mode != MODE_STOP) begin
          mode = MODE_STOP;
          if (now < work_t0) now = work_t0;
          busy_acc = busy_saturate(busy_acc, now - work_t0);
          work_t0 = '0;
        end
      end
      OP_SUSPEND: begin
        ticking = 1'b0;
        mode = MODE_INIT;
        tick_cnt = -1;
        work_t0 = '0;
        busy_acc = '0;
        win_t0 = '0;
      end
      default: begin
        if (ticking) begin
          tick_cnt++;
          if (tick_cnt < int'(period_cfg)) begin
            if (win_t0 == '0) win_t0 = now;
          end else if (busy_acc == '0 && work_t0 == '0) begin
            ratio = '0;
            tick_cnt = 0;
            win_t0 = now;
            r.utilization = '0;
            r.divide_fault = 1'b0;
            ratio_expect.push_back(r);
          end else begin
            span = {1'b0, now} - {1'b0, win_t0};
            if (work_t0 != '0) begin
              if (now > work_t0) busy_acc = busy_saturate(busy_acc, now - work_t0);
              work_t0 = now;
            end
            hi = span[63:32];
            shift = 0;
            for (int b = 0; b < 32; b++) if (hi[b]) shift = b + 1;
            wn = 32'(busy_acc >> shift);
            pn = 32'(span >> shift);
            if (pn > NORM_LIMIT) pn = pn >> 8;
            else wn = wn << 8;
            r.divide_fault = (pn == '0);
            ratio = (pn == '0) ? '0 : wn / pn;
            r.utilization = ratio;
            busy_acc = '0;
            win_t0 = now;
            tick_cnt = 0;
            ratio_expect.push_back(r);
          end
        end
      end
    endcase
  endtask

  // driver: presents the oldest pending word, changes at falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 33)) begin
        in_push <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        in_push <= 1'b0;
      end
      out_pop <= quiet || ($urandom_range(99) >= 33);
    end
  end

  // monitor: compare each popped word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (ratio_expect.size() == 0) begin
          $display("%0t unexpected word: expected none, actual %h/%b", $time,
                   out_data.utilization, out_data.divide_fault);
          errors++;
        end else begin
          if (out_data.utilization !== ratio_expect[0].utilization) begin
            $display("%0t utilization: expected %h, actual %h", $time,
                     ratio_expect[0].utilization, out_data.utilization);
            errors++;
          end
          if (out_data.divide_fault !== ratio_expect[0].divide_fault) begin
            $display("%0t divide_fault: expected %b, actual %b", $time,
                     ratio_expect[0].divide_fault, out_data.divide_fault);
            errors++;
          end
          void'(ratio_expect.pop_front());
        end
      end
      // input word taken at this edge
      if (in_push && !in_full) begin
        predict_utilization(in_data);
        void'(pending_words.pop_front());
      end
      // watchdog on cycles without any handshake
      if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [62:0] rand_time();
    logic [62:0] t;
    t = 63'({$urandom, $urandom});
    case ($urandom_range(3))
      0: t = t & 63'hffff;
      1: t = t & 63'hffff_ffff;
      2: t = t & 63'h3fff_ffff_ffff;
      default: ;
    endcase
    return t;
  endfunction

  task automatic queue_word(logic [1:0] op, logic [62:0] ts);
    in_word_t w;
    w.operation = op;
    w.timestamp = ts;
    pending_words.push_back(w);
  endtask

  // wait until every queued word is in and every report is out
  task automatic drain();
    wait (pending_words.size() == 0 && ratio_expect.size() == 0);
    @(posedge clk);
    wait (!in_push);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    period_cfg = v;
  endtask

  // random busy cycle with mostly increasing time
  task automatic queue_session(int n);
    logic [62:0] t;
    t = rand_time() & 63'hffff_ffff;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) t = rand_time();
      else t = t + $urandom_range(5000);
      case ($urandom_range(19))
        0: queue_word(OP_SUSPEND, t);
        1, 2, 3, 4: queue_word(OP_RUN, t);
        5, 6, 7, 8: queue_word(OP_STOP, t);
        default: queue_word(OP_TICK, t);
      endcase
    end
  endtask

  initial begin
    period_cfg = 16'd1;
    mode = MODE_INIT;
    tick_cnt = -1;
    work_t0 = '0;
    busy_acc = '0;
    win_t0 = '0;
    ticking = 1'b1;
    ratio = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle unit, extremes, backwards time, saturation, zero window
    queue_word(OP_TICK, 63'd100);
    queue_word(OP_TICK, 63'd200);
    queue_word(OP_STOP, 63'd50);
    queue_word(OP_TICK, 63'd300);
    queue_word(OP_RUN, 63'd10);
    queue_word(OP_RUN, 63'd20);
    queue_word(OP_TICK, 63'd400);
    queue_word(OP_RUN, 63'd500);
    queue_word(OP_STOP, 63'd450);
    queue_word(OP_STOP, 63'd460);
    queue_word(OP_TICK, 63'd400);
    queue_word(OP_RUN, 63'd1);
    queue_word(OP_STOP, TIME_MAX);
    queue_word(OP_RUN, 63'd1);
    queue_word(OP_STOP, TIME_MAX);
    queue_word(OP_TICK, TIME_MAX);
    queue_word(OP_RUN, TIME_MAX);
    queue_word(OP_TICK, TIME_MAX);
    queue_word(OP_SUSPEND, 63'd0);
    queue_word(OP_TICK, 63'd900);
    queue_word(OP_RUN, 63'h5555_5555_5555_5555);
    queue_word(OP_TICK, 63'h2aaa_aaaa_aaaa_aaaa);
    queue_word(OP_SUSPEND, TIME_MAX);
    drain();

    // period settings, extremes included; one long stretch without idling
    write_period(16'd0);
    queue_session(300);
    drain();
    write_period(16'hffff);
    queue_word(OP_RUN, 63'd5);
    queue_word(OP_STOP, 63'd7);
    queue_session(100);
    drain();
    write_period(16'd3);
    quiet = 1;
    queue_session(400);
    drain();
    quiet = 0;
    write_period(16'd1);
    queue_session(600);
    drain();
    write_period(16'd2);
    queue_session(600);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/bum_pkg.sv
src/bum_front.sv
src/bum_queue.sv
src/bum_back.sv
src/busy_utilization_monitor.sv
sim/busy_utilization_monitor_test.sv
